[hdl/wthf_pkg.sv]
// Shared types and constants for the waveform threshold hit finder.
// Used by the sample cell, the result register and the core top level.
// Has no dependencies.
package wthf_pkg;

    localparam int PLANE_W    = 2;
    localparam int THRESH_W   = 12;
    localparam int AREA_W     = 26;
    localparam int PEAK_W     = 14;
    localparam int ABOVE_W    = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int OUT_DATA_W = ((AREA_W + PEAK_W + 7) / 8) * 8;

    localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};
    localparam logic [PEAK_W-1:0]  PEAK_MAX  = {PEAK_W{1'b1}};
    localparam logic [ABOVE_W-1:0] ABOVE_MAX = 2'd2;

    // Plane code for negative-going pulses; every other code is positive-going.
    localparam logic [PLANE_W-1:0] PLANE_NEG = 2'd0;

    localparam logic [PLANE_W-1:0]  PLANE_RESET     = 2'd2;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 12'd5;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PLANE     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b1;

    // Open hit being built up, heights in thirds of ADC counts.
    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [PEAK_W-1:0]  peak;
        logic [ABOVE_W-1:0] above;
        logic               in_hit;
    } hit_state_t;

    // A closed hit leaving one sample cell.
    typedef struct packed {
        logic              valid;
        logic [AREA_W-1:0] area;
        logic [PEAK_W-1:0] peak;
    } hit_emit_t;

    // A finished result as held in the output register.
    typedef struct packed {
        logic              tag;
        logic [PEAK_W-1:0] peak;
        logic [AREA_W-1:0] area;
    } hit_result_t;

endpackage

[hdl/wthf_sample_cell.sv]
// One sample step of the hit finder: threshold compare against the baseline,
// area and peak update, and hit close. Purely combinational.
// Depends on wthf_pkg.
module wthf_sample_cell import wthf_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   en,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS+1:0] baseline,
    input  logic [PLANE_W-1:0]     plane,
    input  logic [THRESH_W-1:0]    threshold,
    input  hit_state_t             hit_in,
    output hit_state_t             hit_out,
    output hit_emit_t              emit
);

    localparam int HW = SAMPLE_BITS + 2;
    localparam int MW = THRESH_W + 2;
    localparam int CW = ((HW > MW) ? HW : MW) + 1;

    logic [HW-1:0]     tripled;
    logic [MW-1:0]     margin;
    logic [CW-1:0]     tri_c;
    logic [CW-1:0]     base_c;
    logic [CW-1:0]     marg_c;
    logic              negative;
    logic              pass;
    logic [HW-1:0]     height;
    logic [AREA_W:0]   area_sum;
    logic [PEAK_W-1:0] peak_cand;

    always_comb begin
        tripled  = ({2'b00, sample} << 1) + {2'b00, sample};
        margin   = ({2'b00, threshold} << 1) + {2'b00, threshold};
        tri_c    = CW'(tripled);
        base_c   = CW'(baseline);
        marg_c   = CW'(margin);
        negative = (plane == PLANE_NEG);
        // For negative pulses the sample must sit more than the margin below
        // the baseline; the sum form also rejects a baseline below the margin.
        if (negative) begin
            pass   = (tri_c + marg_c) < base_c;
            height = baseline - tripled;
        end else begin
            pass   = tri_c > (base_c + marg_c);
            height = tripled - baseline;
        end
        area_sum  = {1'b0, hit_in.area} + (AREA_W + 1)'(height);
        peak_cand = (height > HW'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(height);
    end

    always_comb begin
        hit_out = hit_in;
        emit    = '0;
        if (en) begin
            if (pass) begin
                hit_out.in_hit = 1'b1;
                if (hit_in.above < ABOVE_MAX) begin
                    hit_out.above = hit_in.above + 1'b1;
                end
                hit_out.area = area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];
                if (peak_cand > hit_in.peak) begin
                    hit_out.peak = peak_cand;
                end
            end else if (hit_in.in_hit && (hit_in.above >= ABOVE_MAX)) begin
                emit.valid = (hit_in.area != '0);
                emit.area  = hit_in.area;
                emit.peak  = hit_in.peak;
                hit_out    = '0;
            end
        end
    end

endmodule

[hdl/wthf_out_reg.sv]
// Result register of the hit finder: holds one finished hit until the
// downstream side takes it, and reports when it can take a new one.
// Depends on wthf_pkg.
module wthf_out_reg import wthf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  hit_result_t result_in,
    output logic        free,
    output logic        out_valid,
    input  logic        out_ready,
    output hit_result_t result_out
);

    logic        valid_reg;
    logic        valid_next;
    hit_result_t result_reg;

    always_comb begin
        free = !valid_reg || out_ready;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

[hdl/waveform_threshold_hit_finder_core.sv]
// Top level of the waveform threshold hit finder.
// Depends on wthf_pkg, wthf_sample_cell and wthf_out_reg.
// Usage:
//   The s_axis channel carries one ADC sample per request: tdata holds the
//   sample, tlast marks the last sample of a waveform, tuser is the stream tag.
//   The m_axis channel carries one request per closed hit with a positive area:
//   tdata holds area and peak in thirds of ADC counts, tuser echoes the tag of
//   the sample that closed the hit. Samples that close no hit give nothing.
//   Plane and threshold are written through cfg_wr_en/cfg_addr/cfg_wdata while
//   the block is idle; index 0 is the plane, index 1 the threshold.
// Timing:
//   A sample is registered at the edge that accepts it and evaluated in the
//   next cycle; a hit it closes loads the output register once the sample
//   advances, which waits while that register holds an untaken hit; otherwise
//   one sample per cycle is sustained. The third sample of a waveform runs
//   all three baseline samples through a chain of three sample cells at once.
// Reset and stall:
//   Reset sets plane to 2, threshold to 5 and clears the waveform position, the open hit and the valid flags.
//   While m_axis is stalled with a hit waiting, samples keep flowing until
//   another hit would close; then s_axis_tready drops until the hit is taken.
module waveform_threshold_hit_finder_core import wthf_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [THRESH_W-1:0]    cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, rest zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                   s_axis_tlast,
    // [0] stream_tag
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [25:0] area, [39:26] peak
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] hit_tag
    output logic                   m_axis_tuser
);

    localparam int BW = SAMPLE_BITS + 2;

    localparam logic [1:0] POS_HOLD0 = 2'd0;
    localparam logic [1:0] POS_HOLD1 = 2'd1;
    localparam logic [1:0] POS_THIRD = 2'd2;
    localparam logic [1:0] POS_RUN   = 2'd3;

    // Configuration.
    logic [PLANE_W-1:0]  plane_reg;
    logic [THRESH_W-1:0] threshold_reg;

    // Input register.
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_last_reg;
    logic                   in_tag_reg;

    // Waveform state.
    logic [1:0]             pos_reg;
    logic [1:0]             pos_next;
    logic [SAMPLE_BITS-1:0] held0_reg;
    logic [SAMPLE_BITS-1:0] held0_next;
    logic [SAMPLE_BITS-1:0] held1_reg;
    logic [SAMPLE_BITS-1:0] held1_next;
    logic [BW-1:0]          base_reg;
    logic [BW-1:0]          base_next;
    hit_state_t             hit_reg;
    hit_state_t             hit_next;

    logic          at_third;
    logic          running;
    logic [BW-1:0] sum3;
    logic [BW-1:0] base_now;
    hit_state_t    hit_a;
    hit_state_t    hit_b;
    hit_state_t    hit_c;
    hit_emit_t     emit_a;
    hit_emit_t     emit_b;
    hit_emit_t     emit_c;
    logic          emit;
    hit_result_t   result;
    hit_result_t   result_out;
    logic          out_free;
    logic          advance;
    logic          in_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg     <= PLANE_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PLANE:     plane_reg     <= cfg_wdata[PLANE_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_wdata;
            endcase
        end
    end

    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            in_last_reg   <= s_axis_tlast;
            in_tag_reg    <= s_axis_tuser;
        end
    end

    // The baseline is formed when the third sample arrives and used at once.
    assign at_third = (pos_reg == POS_THIRD);
    assign running  = (pos_reg == POS_THIRD) || (pos_reg == POS_RUN);
    assign sum3     = BW'(held0_reg) + BW'(held1_reg) + BW'(in_sample_reg);
    assign base_now = at_third ? sum3 : base_reg;

    wthf_sample_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_a (
        .en        (at_third),
        .sample    (held0_reg),
        .baseline  (base_now),
        .plane     (plane_reg),
        .threshold (threshold_reg),
        .hit_in    (hit_reg),
        .hit_out   (hit_a),
        .emit      (emit_a)
    );

    wthf_sample_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_b (
        .en        (at_third),
        .sample    (held1_reg),
        .baseline  (base_now),
        .plane     (plane_reg),
        .threshold (threshold_reg),
        .hit_in    (hit_a),
        .hit_out   (hit_b),
        .emit      (emit_b)
    );

    wthf_sample_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell_c (
        .en        (running),
        .sample    (in_sample_reg),
        .baseline  (base_now),
        .plane     (plane_reg),
        .threshold (threshold_reg),
        .hit_in    (hit_b),
        .hit_out   (hit_c),
        .emit      (emit_c)
    );

    // At most one of the three cells closes a hit in any cycle.
    always_comb begin
        emit       = emit_a.valid || emit_b.valid || emit_c.valid;
        result.tag = in_tag_reg;
        priority if (emit_a.valid) begin
            result.area = emit_a.area;
            result.peak = emit_a.peak;
        end else if (emit_b.valid) begin
            result.area = emit_b.area;
            result.peak = emit_b.peak;
        end else begin
            result.area = emit_c.area;
            result.peak = emit_c.peak;
        end
    end

    assign advance = in_valid_reg && (!emit || out_free);

    always_comb begin
        pos_next   = pos_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        base_next  = base_reg;
        hit_next   = hit_reg;
        if (advance) begin
            unique case (pos_reg)
                POS_HOLD0: begin
                    held0_next = in_sample_reg;
                    pos_next   = POS_HOLD1;
                end
                POS_HOLD1: begin
                    held1_next = in_sample_reg;
                    pos_next   = POS_THIRD;
                end
                POS_THIRD: begin
                    base_next = sum3;
                    hit_next  = hit_c;
                    pos_next  = POS_RUN;
                end
                POS_RUN: begin
                    hit_next = hit_c;
                end
            endcase
            // The end of a waveform drops any open hit and starts over.
            if (in_last_reg) begin
                pos_next = POS_HOLD0;
                hit_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HOLD0;
            hit_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        base_reg  <= base_next;
    end

    wthf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && emit),
        .result_in  (result),
        .free       (out_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result_out (result_out)
    );

    assign m_axis_tdata = OUT_DATA_W'({result_out.peak, result_out.area});
    assign m_axis_tuser = result_out.tag;

endmodule

[tb/waveform_threshold_hit_finder_core_test.sv]
// Self-checking testbench for the waveform threshold hit finder core.
// Depends on wthf_pkg and waveform_threshold_hit_finder_core; drives random
// waveforms through the stream ports and checks every hit against a predictor.
module waveform_threshold_hit_finder_core_test import wthf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PLANE_W-1:0] PLANE_POS1  = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_POS2  = 2'd2;
    localparam logic [PLANE_W-1:0] PLANE_SPARE = 2'd3;
    localparam int SAMPLE_MAX   = 4095;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    // Predicts hits from accepted samples and matches them against the block.
    class hit_scoreboard;
        logic [PLANE_W-1:0]  plane;
        logic [THRESH_W-1:0] threshold;
        logic [11:0]         held [2];
        int unsigned         position;
        int unsigned         baseline;
        int unsigned         area;
        int unsigned         peak;
        int unsigned         above;
        bit                  in_hit;
        int unsigned         closed_area;
        int unsigned         closed_peak;
        hit_result_t         expected_hits [$];
        int                  errors;

        function new();
            plane = PLANE_RESET;
            threshold = THRESHOLD_RESET;
            errors = 0;
            clear_waveform();
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [THRESH_W-1:0] value);
            if (idx == REG_PLANE) begin
                plane = value[PLANE_W-1:0];
            end else begin
                threshold = value;
            end
        endfunction

        function void clear_hit();
            area = 0;
            peak = 0;
            above = 0;
            in_hit = 0;
        endfunction

        function void clear_waveform();
            held[0] = '0;
            held[1] = '0;
            position = 0;
            baseline = 0;
            clear_hit();
        endfunction

        // Runs one sample against the baseline; true when a hit closes with area.
        function bit eval_sample(logic [11:0] s);
            int unsigned tripled;
            int unsigned margin;
            int unsigned height;
            bit          pass;
            bit          emit;
            tripled = 3 * s;
            margin = 3 * threshold;
            height = 0;
            if (plane == PLANE_NEG) begin
                pass = (baseline > margin) && (tripled < baseline - margin);
                if (pass) height = baseline - tripled;
            end else begin
                pass = tripled > baseline + margin;
                if (pass) height = tripled - baseline;
            end
            if (pass) begin
                in_hit = 1;
                if (above < ABOVE_MAX) above++;
                if (height > AREA_MAX - area) area = AREA_MAX;
                else area = area + height;
                if (height > PEAK_MAX) height = PEAK_MAX;
                if (height > peak) peak = height;
                return 0;
            end
            if (in_hit && above >= 2) begin
                emit = area > 0;
                closed_area = area;
                closed_peak = peak;
                clear_hit();
                return emit;
            end
            return 0;
        endfunction

        function void note_sample(logic [11:0] s, logic last, logic tag);
            bit          closed;
            hit_result_t hit;
            closed = 0;
            if (position < 2) begin
                held[position] = s;
                position++;
            end else if (position == 2) begin
                baseline = held[0] + held[1] + s;
                if (eval_sample(held[0])) closed = 1;
                if (eval_sample(held[1])) closed = 1;
                if (eval_sample(s)) closed = 1;
                position = 3;
            end else begin
                closed = eval_sample(s);
            end
            if (last) clear_waveform();
            if (closed) begin
                hit.tag = tag;
                hit.peak = closed_peak[PEAK_W-1:0];
                hit.area = closed_area[AREA_W-1:0];
                expected_hits.push_back(hit);
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t: hit check failed: %s", $time, msg);
            errors++;
        endtask

        task check_hit(logic [AREA_W-1:0] a, logic [PEAK_W-1:0] p, logic tag);
            hit_result_t want;
            if (expected_hits.size() == 0) begin
                report_mismatch($sformatf("unexpected hit area %0d peak %0d tag %0d", a, p, tag));
                return;
            end
            want = expected_hits.pop_front();
            if (a != want.area)
                report_mismatch($sformatf("area %0d, predicted %0d", a, want.area));
            if (p != want.peak)
                report_mismatch($sformatf("peak %0d, predicted %0d", p, want.peak));
            if (tag != want.tag)
                report_mismatch($sformatf("tag %0d, predicted %0d", tag, want.tag));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [THRESH_W-1:0]   cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    hit_scoreboard hits = new();
    bit idle_on;
    bit hold_req;

    waveform_threshold_hit_finder_core #(.SAMPLE_BITS(12)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Both channels are observed at the same edge that completes each request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                hits.check_hit(m_axis_tdata[AREA_W-1:0], m_axis_tdata[AREA_W+PEAK_W-1:AREA_W],
                               m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                hits.note_sample(s_axis_tdata[11:0], s_axis_tlast, s_axis_tuser);
        end
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        int stall;
        m_axis_tready = 0;
        @(posedge aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                stall = HOLD_CYCLES;
            end else begin
                stall = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    task send_sample(int value, bit last, bit tag);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'b0, value[11:0]};
        s_axis_tlast <= last;
        s_axis_tuser <= tag;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task wait_idle();
        while (hits.expected_hits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task configure(logic [PLANE_W-1:0] plane, logic [THRESH_W-1:0] thr);
        cfg_wr_en <= 1;
        cfg_addr <= REG_PLANE;
        cfg_wdata <= {{(THRESH_W-PLANE_W){1'b0}}, plane};
        @(posedge aclk);
        cfg_addr <= REG_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_wr_en <= 0;
        hits.set_register(REG_PLANE, {{(THRESH_W-PLANE_W){1'b0}}, plane});
        hits.set_register(REG_THRESHOLD, thr);
    endtask

    // A waveform settles on a baseline for three samples, then mixes noise with
    // pulses of random width; a few pulses go the wrong way or are cut short.
    task send_random_waveform(output int len);
        int base;
        int v;
        int sign;
        int pulse_left;
        len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(1, 2))
                                            : int'($urandom_range(3, 24));
        base = $urandom_range(0, SAMPLE_MAX);
        pulse_left = 0;
        sign = 1;
        for (int i = 0; i < len; i++) begin
            if (i >= 3 && pulse_left == 0 && $urandom_range(0, 9) < 3) begin
                pulse_left = $urandom_range(1, 5);
                sign = (hits.plane == PLANE_NEG) ? -1 : 1;
                if ($urandom_range(0, 7) == 0) sign = -sign;
            end
            if (i >= 3 && pulse_left > 0) begin
                v = base + sign * (int'(hits.threshold) + int'($urandom_range(1, 300)));
                pulse_left--;
            end else begin
                v = base + int'($urandom_range(0, 4)) - 2;
            end
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            send_sample(v, i == len - 1, 1'($urandom_range(0, 1)));
        end
    endtask

    task run_phase(logic [PLANE_W-1:0] plane, int thr, int items, bit idle, bit pressure);
        int sent;
        int len;
        wait_idle();
        configure(plane, thr[THRESH_W-1:0]);
        idle_on = idle;
        if (pressure) hold_req = 1;
        sent = 0;
        while (sent < items) begin
            send_random_waveform(len);
            sent += len;
        end
        s_axis_tvalid <= 0;
    endtask

    // Directed waveforms under the reset settings: short waveforms, a hit that
    // closes on the third sample, a lone passing sample that keeps the hit open,
    // an open hit dropped at the end and a hit closed by the last sample.
    int  directed_sample [26] = '{4095,
                                  0, 4095,
                                  4095, 4095, 0, 0,
                                  10, 10, 10, 40, 10, 40, 10, 10,
                                  10, 10, 10, 40, 40,
                                  10, 10, 10, 40, 40, 10};
    bit  directed_last [26]   = '{1,
                                  0, 1,
                                  0, 0, 0, 1,
                                  0, 0, 0, 0, 0, 0, 0, 1,
                                  0, 0, 0, 0, 1,
                                  0, 0, 0, 0, 0, 1};

    initial begin
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        s_axis_tuser = 0;
        idle_on = 1;
        hold_req = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        for (int i = 0; i < 26; i++)
            send_sample(directed_sample[i], directed_last[i], i[0]);
        s_axis_tvalid <= 0;

        run_phase(PLANE_NEG, 12, 200, 1, 0);
        run_phase(PLANE_POS1, 0, 200, 0, 1);
        run_phase(PLANE_SPARE, 40, 200, 1, 0);
        run_phase(PLANE_POS2, SAMPLE_MAX, 50, 1, 0);
        run_phase(PLANE_NEG, 0, 200, 1, 0);
        run_phase(PLANE_POS1, 25, 200, 0, 0);

        wait_idle();
        if (hits.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
